// ===== rtl/core/u1pgf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u1pgf_pkg
// Shared constants, command type and link address mapping for the U(1)
// plaquette gauge force block.
// ----------------------------------------------------------------------------
package u1pgf_pkg;

  // Lattice geometry
  localparam int X_SIZE = 16;
  localparam int Y_SIZE = 16;
  localparam int Z_SIZE = 5;
  localparam int FRAC_BITS = 16;

  localparam int LINK_COUNT = X_SIZE * Y_SIZE * Z_SIZE * 2;
  localparam int ADDR_W = $clog2(LINK_COUNT);

  // Port field widths
  localparam int XW = 4;
  localparam int YW = 4;
  localparam int ZW = 3;
  localparam int LW = 18;             // one part of a link value
  localparam int LINK_W = 2 * LW;     // stored link: {real, imag}
  localparam int BETA_W = 16;
  localparam int RES_W = 28;
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // Datapath widths: three chained products stay below 2^24
  localparam int ACC_W = 26;
  localparam int OPW = LW + 1;        // link part after conjugation
  localparam int PROD_W = ACC_W + OPW;
  localparam int SUM_W = PROD_W + 1;
  localparam int FW = (BETA_W + 1) + (ACC_W + 1);
  localparam int RW = FW + 1 - 8;

  // Command queue
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register word index (paddr[2])
  localparam logic REG_BETA_INPLANE = 1'b0;
  localparam logic REG_BETA_SLICES = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic                 ok;
    logic [XW-1:0]        x;
    logic [XW-1:0]        xp;
    logic [XW-1:0]        xm;
    logic [YW-1:0]        y;
    logic [YW-1:0]        yp;
    logic [YW-1:0]        ym;
    logic [ZW-1:0]        z;
    logic [ZW-1:0]        zp;
    logic [ZW-1:0]        zm;
    logic                 z_up;
    logic                 z_dn;
    logic                 d;
    logic signed [LW-1:0] re;
    logic signed [LW-1:0] im;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] link_addr(input logic [XW-1:0] x,
                                                  input logic [YW-1:0] y,
                                                  input logic [ZW-1:0] z,
                                                  input logic d);
    int a;
    a = ((int'(x) * Y_SIZE + int'(y)) * Z_SIZE + int'(z)) * 2 + int'(d);
    return ADDR_W'(a);
  endfunction

endpackage

// ===== rtl/core/u1pgf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u1pgf_front
// Accepts items, checks coordinates and works out the wrapped neighbors.
// ----------------------------------------------------------------------------
module u1pgf_front (
  input  logic                          push,
  output logic                          full,
  input  logic                          in_kind,
  input  logic [u1pgf_pkg::XW-1:0]      in_site_x,
  input  logic [u1pgf_pkg::YW-1:0]      in_site_y,
  input  logic [u1pgf_pkg::ZW-1:0]      in_site_z,
  input  logic                          in_link_dir,
  input  logic signed [u1pgf_pkg::LW-1:0] in_link_real,
  input  logic signed [u1pgf_pkg::LW-1:0] in_link_imag,
  input  logic                          q_full,
  output logic                          q_push,
  output u1pgf_pkg::cmd_t               q_data
);

  assign full = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data.kind = in_kind;
    q_data.ok = (int'(in_site_x) < u1pgf_pkg::X_SIZE) &&
                (int'(in_site_y) < u1pgf_pkg::Y_SIZE) &&
                (int'(in_site_z) < u1pgf_pkg::Z_SIZE);
    q_data.x = in_site_x;
    q_data.y = in_site_y;
    q_data.z = in_site_z;
    q_data.d = in_link_dir;
    q_data.re = in_link_real;
    q_data.im = in_link_imag;
    // periodic wrap in x and y
    q_data.xp = (int'(in_site_x) == u1pgf_pkg::X_SIZE - 1) ? '0
              : u1pgf_pkg::XW'(in_site_x + 1'b1);
    q_data.xm = (in_site_x == '0) ? u1pgf_pkg::XW'(u1pgf_pkg::X_SIZE - 1)
              : u1pgf_pkg::XW'(in_site_x - 1'b1);
    q_data.yp = (int'(in_site_y) == u1pgf_pkg::Y_SIZE - 1) ? '0
              : u1pgf_pkg::YW'(in_site_y + 1'b1);
    q_data.ym = (in_site_y == '0) ? u1pgf_pkg::YW'(u1pgf_pkg::Y_SIZE - 1)
              : u1pgf_pkg::YW'(in_site_y - 1'b1);
    // open ends in z
    q_data.zp = u1pgf_pkg::ZW'(in_site_z + 1'b1);
    q_data.zm = u1pgf_pkg::ZW'(in_site_z - 1'b1);
    q_data.z_up = (int'(in_site_z) + 1) < u1pgf_pkg::Z_SIZE;
    q_data.z_dn = (in_site_z != '0);
  end

endmodule

// ===== rtl/core/u1pgf_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u1pgf_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module u1pgf_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  input  u1pgf_pkg::cmd_t q_data,
  output logic            q_full,
  input  logic            q_pop,
  output logic            q_empty,
  output u1pgf_pkg::cmd_t q_head
);

  u1pgf_pkg::cmd_t                  ent_r [u1pgf_pkg::CMDQ_DEPTH];
  logic [u1pgf_pkg::CMDQ_AW-1:0]    wp_r;
  logic [u1pgf_pkg::CMDQ_AW-1:0]    rp_r;
  logic [u1pgf_pkg::CMDQ_AW:0]      cnt_r;

  assign q_full = (int'(cnt_r) == u1pgf_pkg::CMDQ_DEPTH);
  assign q_empty = (cnt_r == '0);
  assign q_head = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (q_push) begin
      ent_r[wp_r] <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (q_push) begin
        wp_r <= u1pgf_pkg::CMDQ_AW'(wp_r + 1'b1);
      end
      if (q_pop) begin
        rp_r <= u1pgf_pkg::CMDQ_AW'(rp_r + 1'b1);
      end
      cnt_r <= (u1pgf_pkg::CMDQ_AW+1)'(cnt_r + q_push - q_pop);
    end
  end

endmodule

// ===== rtl/core/u1pgf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u1pgf_back
// Link store, plaquette sequencer with a shared complex multiplier, force
// sum and a two-entry result queue.
// ----------------------------------------------------------------------------
module u1pgf_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  u1pgf_pkg::cmd_t                     cmd,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  input  logic [u1pgf_pkg::BETA_W-1:0]        beta_i,
  input  logic [u1pgf_pkg::BETA_W-1:0]        beta_z,
  output logic                                res_empty,
  input  logic                                res_pop,
  output logic signed [u1pgf_pkg::RES_W-1:0]  res_force
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_ADD, S_FIN1, S_FIN2} state_t;

  localparam int ACC_W = u1pgf_pkg::ACC_W;
  localparam int OPW = u1pgf_pkg::OPW;
  localparam int PROD_W = u1pgf_pkg::PROD_W;
  localparam int SUM_W = u1pgf_pkg::SUM_W;
  localparam int FW = u1pgf_pkg::FW;
  localparam int RW = u1pgf_pkg::RW;
  localparam int LW = u1pgf_pkg::LW;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1 << (u1pgf_pkg::FRAC_BITS - 1));
  localparam logic signed [FW:0] FHALF = (FW+1)'(128);
  localparam logic signed [RW-1:0] OUT_MAX = RW'((1 << 27) - 1);
  localparam logic signed [RW-1:0] OUT_MIN = RW'(-(1 << 27));

  state_t                          state_r;
  logic [3:0]                      step_r;
  u1pgf_pkg::cmd_t                 cur_r;
  logic [u1pgf_pkg::LINK_W-1:0]    link_mem_r [u1pgf_pkg::LINK_COUNT];
  logic [u1pgf_pkg::LINK_W-1:0]    rd_data_r;
  logic signed [ACC_W-1:0]         acc_re_r, acc_im_r;
  logic signed [PROD_W-1:0]        pr_rr_r, pr_ii_r, pr_ri_r, pr_ir_r;
  logic signed [ACC_W-1:0]         t_p0_r, t_q_r, t_zu_r, t_zd_r;
  logic signed [FW-1:0]            fa_r, fz_r;

  // result queue
  logic signed [u1pgf_pkg::RES_W-1:0] rq_r [2];
  logic                            rq_wp_r, rq_rp_r;
  logic [1:0]                      rq_cnt_r;
  logic                            res_push;
  logic signed [u1pgf_pkg::RES_W-1:0] res_data;

  // step decode
  logic [u1pgf_pkg::XW-1:0]        sx;
  logic [u1pgf_pkg::YW-1:0]        sy;
  logic [u1pgf_pkg::ZW-1:0]        sz;
  logic                            sd, s_conj, s_first, s_last;
  logic [u1pgf_pkg::ADDR_W-1:0]    rd_addr;
  logic [3:0]                      step_nxt;
  logic                            done_nxt;

  logic signed [OPW-1:0]           op_re, op_im;
  logic signed [SUM_W-1:0]         sum_re, sum_im;
  logic signed [ACC_W-1:0]         rnd_re, rnd_im;
  logic signed [ACC_W:0]           diff_ab, diff_z;
  logic signed [FW:0]              fsum;
  logic signed [RW-1:0]            fround;
  logic signed [u1pgf_pkg::RES_W-1:0] fsat;

  always_comb begin
    sx = cur_r.x;
    sy = cur_r.y;
    sz = cur_r.z;
    sd = cur_r.d;
    s_conj = 1'b0;
    s_first = 1'b0;
    s_last = 1'b0;
    case (step_r)
      4'd0: begin sd = 1'b0; s_first = 1'b1; end
      4'd1: begin sx = cur_r.xp; sd = 1'b1; end
      4'd2: begin sy = cur_r.yp; sd = 1'b0; s_conj = 1'b1; end
      4'd3: begin sd = 1'b1; s_conj = 1'b1; s_last = 1'b1; end
      4'd4: begin
        s_first = 1'b1;
        sd = 1'b1;
        if (!cur_r.d) begin
          sy = cur_r.ym;
          s_conj = 1'b1;
        end
      end
      4'd5: begin
        if (!cur_r.d) begin
          sy = cur_r.ym; sd = 1'b0;
        end else begin
          sx = cur_r.xm; sy = cur_r.yp; sd = 1'b0; s_conj = 1'b1;
        end
      end
      4'd6: begin
        sd = 1'b1;
        if (!cur_r.d) begin
          sx = cur_r.xp; sy = cur_r.ym;
        end else begin
          sx = cur_r.xm; s_conj = 1'b1;
        end
      end
      4'd7: begin
        sd = 1'b0;
        s_last = 1'b1;
        if (!cur_r.d) begin
          s_conj = 1'b1;
        end else begin
          sx = cur_r.xm;
        end
      end
      4'd8: begin s_first = 1'b1; end
      4'd9: begin sz = cur_r.zp; s_conj = 1'b1; s_last = 1'b1; end
      4'd10: begin sz = cur_r.zm; s_first = 1'b1; end
      4'd11: begin s_conj = 1'b1; s_last = 1'b1; end
      default: begin end
    endcase
  end

  assign rd_addr = u1pgf_pkg::link_addr(sx, sy, sz, sd);

  // skip the z terms that fall off the open ends
  always_comb begin
    step_nxt = 4'(step_r + 1'b1);
    done_nxt = 1'b0;
    case (step_r)
      4'd7: begin
        if (cur_r.z_up) begin
          step_nxt = 4'd8;
        end else if (cur_r.z_dn) begin
          step_nxt = 4'd10;
        end else begin
          done_nxt = 1'b1;
        end
      end
      4'd9: begin
        if (!cur_r.z_dn) begin
          done_nxt = 1'b1;
        end
      end
      4'd11: done_nxt = 1'b1;
      default: begin end
    endcase
  end

  always_comb begin
    op_re = OPW'($signed(rd_data_r[u1pgf_pkg::LINK_W-1:LW]));
    op_im = OPW'($signed(rd_data_r[LW-1:0]));
    if (s_conj) begin
      op_im = -op_im;
    end
    sum_re = SUM_W'(pr_rr_r) - SUM_W'(pr_ii_r) + HALF;
    sum_im = SUM_W'(pr_ri_r) + SUM_W'(pr_ir_r) + HALF;
    rnd_re = ACC_W'(sum_re >>> u1pgf_pkg::FRAC_BITS);
    rnd_im = ACC_W'(sum_im >>> u1pgf_pkg::FRAC_BITS);
    diff_ab = cur_r.d ? ((ACC_W+1)'(t_q_r) - (ACC_W+1)'(t_p0_r))
                      : ((ACC_W+1)'(t_p0_r) - (ACC_W+1)'(t_q_r));
    diff_z = (ACC_W+1)'(t_zu_r) - (ACC_W+1)'(t_zd_r);
    fsum = (FW+1)'(fa_r) + (FW+1)'(fz_r) + FHALF;
    fround = RW'(fsum >>> 8);
    if (fround > OUT_MAX) begin
      fsat = u1pgf_pkg::RES_W'(OUT_MAX);
    end else if (fround < OUT_MIN) begin
      fsat = u1pgf_pkg::RES_W'(OUT_MIN);
    end else begin
      fsat = u1pgf_pkg::RES_W'(fround);
    end
  end

  assign cmd_pop = (state_r == S_IDLE) && !cmd_empty &&
                   ((cmd.kind == u1pgf_pkg::KIND_WRITE) || (rq_cnt_r != 2'd2));

  always_comb begin
    res_push = 1'b0;
    res_data = fsat;
    if (cmd_pop && (cmd.kind == u1pgf_pkg::KIND_QUERY) && !cmd.ok) begin
      res_push = 1'b1;
      res_data = '0;
    end else if (state_r == S_FIN2) begin
      res_push = 1'b1;
    end
  end

  // link store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == u1pgf_pkg::KIND_WRITE) && cmd.ok) begin
      link_mem_r[u1pgf_pkg::link_addr(cmd.x, cmd.y, cmd.z, cmd.d)] <= {cmd.re, cmd.im};
    end
    if (state_r == S_RD) begin
      rd_data_r <= link_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop && (cmd.kind == u1pgf_pkg::KIND_QUERY) && cmd.ok) begin
            cur_r <= cmd;
            step_r <= '0;
            t_zu_r <= '0;
            t_zd_r <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_MUL;
        S_MUL: begin
          if (s_first) begin
            acc_re_r <= ACC_W'(op_re);
            acc_im_r <= ACC_W'(op_im);
            step_r <= step_nxt;
            state_r <= S_RD;
          end else begin
            pr_rr_r <= acc_re_r * op_re;
            pr_ii_r <= acc_im_r * op_im;
            pr_ri_r <= acc_re_r * op_im;
            pr_ir_r <= acc_im_r * op_re;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          acc_re_r <= rnd_re;
          acc_im_r <= rnd_im;
          if (s_last) begin
            case (step_r[3:1])
              3'd1: t_p0_r <= rnd_im;
              3'd3: t_q_r <= rnd_im;
              3'd4: t_zu_r <= rnd_im;
              default: t_zd_r <= rnd_im;
            endcase
          end
          step_r <= step_nxt;
          state_r <= done_nxt ? S_FIN1 : S_RD;
        end
        S_FIN1: begin
          fa_r <= $signed({1'b0, beta_i}) * diff_ab;
          fz_r <= $signed({1'b0, beta_z}) * diff_z;
          state_r <= S_FIN2;
        end
        S_FIN2: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_empty = (rq_cnt_r == 2'd0);
  assign res_force = rq_r[rq_rp_r];

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq_r[rq_wp_r] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r <= 1'b0;
      rq_rp_r <= 1'b0;
      rq_cnt_r <= '0;
    end else begin
      if (res_push) begin
        rq_wp_r <= !rq_wp_r;
      end
      if (res_pop && !res_empty) begin
        rq_rp_r <= !rq_rp_r;
      end
      rq_cnt_r <= 2'(rq_cnt_r + res_push - (res_pop && !res_empty));
    end
  end

endmodule

// ===== rtl/core/u1_plaquette_gauge_force_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u1_plaquette_gauge_force_top
// U(1) Wilson plaquette gauge force engine with an on-chip link store.
// ----------------------------------------------------------------------------
// Write items store one Q1.16 complex link of a 16x16x5 lattice (x and y
// links); query items return the saturated Q11.16 force on one link. The
// front checks coordinates and forms wrapped neighbors, a four-entry command
// queue decouples it from the back, which works one command at a time. A
// query reads its links one after the other from the one read port of the
// link store and feeds a shared complex multiplier: a load step passes
// S_RD and S_MUL, a multiply step S_RD, S_MUL and S_ADD. A query has one z
// term at both z ends and two inside the stack, and ends with the beta sum
// in S_FIN1 and S_FIN2. Coordinates out of range drop a write and give a
// zero result for a query. The store has no reset; query only links that
// were written. Configure betas only while idle.
// ----------------------------------------------------------------------------
module u1_plaquette_gauge_force_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 in_kind,
  input  logic [3:0]                           in_site_x,
  input  logic [3:0]                           in_site_y,
  input  logic [2:0]                           in_site_z,
  input  logic                                 in_link_dir,
  input  logic signed [17:0]                   in_link_real,
  input  logic signed [17:0]                   in_link_imag,
  // result channel
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [27:0]                   out_force_res,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [u1pgf_pkg::CFG_AW-1:0]         paddr,
  input  logic [u1pgf_pkg::CFG_DW-1:0]         pwdata,
  output logic [u1pgf_pkg::CFG_DW-1:0]         prdata,
  output logic                                 pready
);

  logic [u1pgf_pkg::BETA_W-1:0] beta_i_r;
  logic [u1pgf_pkg::BETA_W-1:0] beta_z_r;
  logic                         cfg_wr;

  logic            q_push, q_full, q_pop, q_empty;
  u1pgf_pkg::cmd_t q_data, q_head;

  // Register file: transfer completes in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      u1pgf_pkg::REG_BETA_INPLANE: prdata = u1pgf_pkg::CFG_DW'(beta_i_r);
      u1pgf_pkg::REG_BETA_SLICES:  prdata = u1pgf_pkg::CFG_DW'(beta_z_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_i_r <= u1pgf_pkg::BETA_W'(256);
      beta_z_r <= u1pgf_pkg::BETA_W'(256);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        u1pgf_pkg::REG_BETA_INPLANE: beta_i_r <= pwdata[u1pgf_pkg::BETA_W-1:0];
        u1pgf_pkg::REG_BETA_SLICES:  beta_z_r <= pwdata[u1pgf_pkg::BETA_W-1:0];
        default: begin end
      endcase
    end
  end

  // Front: accept and classify
  u1pgf_front u_front (
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_site_x    (in_site_x),
    .in_site_y    (in_site_y),
    .in_site_z    (in_site_z),
    .in_link_dir  (in_link_dir),
    .in_link_real (in_link_real),
    .in_link_imag (in_link_imag),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  // Hold commands while the back is busy
  u1pgf_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_data  (q_data),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Back: link store, force sequencer, result queue
  u1pgf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_head),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .beta_i    (beta_i_r),
    .beta_z    (beta_z_r),
    .res_empty (empty),
    .res_pop   (pop),
    .res_force (out_force_res)
  );

endmodule
